// ===== hdl/eusa_pkg.sv =====
// Shared types, codes and field layout of the expert union slot assigner.
package eusa_pkg;

	localparam int COMMAND_W = 2;
	localparam int COLUMN_W  = 3;
	localparam int ID_W      = 10;
	localparam int WEIGHT_W  = 32;
	localparam int STATUS_W  = 2;
	localparam int SLOT_W    = 6;
	localparam int EC_W      = 10;
	localparam int CAP_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 10;

	localparam logic [COMMAND_W-1:0] CMD_START = 2'd0;
	localparam logic [COMMAND_W-1:0] CMD_ENTRY = 2'd1;
	localparam logic [COMMAND_W-1:0] CMD_END   = 2'd2;

	localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STS_RANGE    = 2'd1;
	localparam logic [STATUS_W-1:0] STS_OVERFLOW = 2'd2;
	localparam logic [STATUS_W-1:0] STS_SKIPPED  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_EXPERT_COUNT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_CAPACITY = 1'd1;

	localparam logic [EC_W-1:0]  EXPERT_COUNT_RST  = 10'd512;
	localparam logic [CAP_W-1:0] SLOT_CAPACITY_RST = 7'd64;

	// input tdata layout
	localparam int IN_COL_LSB = 0;
	localparam int IN_ID_LSB  = IN_COL_LSB + COLUMN_W;
	localparam int IN_WT_LSB  = IN_ID_LSB + ID_W;
	localparam int IN_USED_W  = IN_WT_LSB + WEIGHT_W;
	localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

	// output tdata layout
	localparam int OUT_SLOT_LSB   = 0;
	localparam int OUT_NEW_LSB    = OUT_SLOT_LSB + SLOT_W;
	localparam int OUT_COL_LSB    = OUT_NEW_LSB + 1;
	localparam int OUT_WT_LSB     = OUT_COL_LSB + COLUMN_W;
	localparam int OUT_COUNT_LSB  = OUT_WT_LSB + WEIGHT_W;
	localparam int OUT_SHARED_LSB = OUT_COUNT_LSB + SLOT_W;
	localparam int OUT_USED_W     = OUT_SHARED_LSB + SLOT_W;
	localparam int OUT_TDATA_W    = ((OUT_USED_W + 7) / 8) * 8;

endpackage

// ===== hdl/expert_union_slot_assigner_unit.sv =====
// Top level of the expert union slot assigner: id-to-slot map and slot owner memories.
//
//  channel   dir  handshake          payload
//  s_*       in   tvalid/tready      tuser: command; tdata: column, expert_id, weight_bits
//  m_*       out  tvalid/tready      tuser: status; tlast: batch_done; tdata: see port
//  cfg_*     in   cfg_wen            cfg_addr: register index; cfg_wdata: value
//
// A routing entry does a map read, then the write back of map and owner.
// An end command loads its result as it is taken; a start command walks the union
// with one owner read and one map clear per assigned slot.
// After reset a clearing pass over all MAX_EXPERTS map entries runs before the first item.
// An item is taken only while the result register is empty or being drained.
module expert_union_slot_assigner_unit #(
	parameter int MAX_EXPERTS = 512,
	parameter int MAX_SLOTS   = 64,
	parameter int MAX_COLUMNS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [2:0] column, [12:3] expert_id, [44:13] weight_bits, [47:45] zero
	input  logic [eusa_pkg::IN_TDATA_W-1:0]      s_tdata,
	// [1:0] command
	input  logic [eusa_pkg::COMMAND_W-1:0]       s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [5:0] slot, [6] is_new, [9:7] out_column, [41:10] out_weight_bits,
	// [47:42] routed_count, [53:48] shared_slot, [55:54] zero
	output logic [eusa_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// [1:0] status
	output logic [eusa_pkg::STATUS_W-1:0]        m_tuser,
	output logic                                 m_tlast,
	input  logic                                 cfg_wen,
	input  logic [eusa_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  logic [eusa_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	localparam int EW = (MAX_EXPERTS > 1) ? $clog2(MAX_EXPERTS) : 1;
	localparam int SW = $clog2(MAX_SLOTS);
	localparam int MW = SW + 1;

	localparam logic [1:0] ST_CLR  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_LOOK = 2'd2;
	localparam logic [1:0] ST_WALK = 2'd3;

	logic [1:0]                     state_q;
	logic [EW-1:0]                  clr_cnt_q;
	logic [SW-1:0]                  walk_cnt_q;
	logic                           walk_pend_q;
	logic [SW-1:0]                  rt_q;
	logic                           err_q;
	logic                           out_valid_q;
	logic [eusa_pkg::EC_W-1:0]      expert_count_q;
	logic [eusa_pkg::CAP_W-1:0]     slot_capacity_q;

	logic [eusa_pkg::COLUMN_W-1:0]  col_q;
	logic [eusa_pkg::ID_W-1:0]      id_q;
	logic [eusa_pkg::WEIGHT_W-1:0]  wt_q;

	logic [eusa_pkg::STATUS_W-1:0]  status_q;
	logic [eusa_pkg::SLOT_W-1:0]    slot_q;
	logic                           is_new_q;
	logic [eusa_pkg::COLUMN_W-1:0]  out_col_q;
	logic [eusa_pkg::WEIGHT_W-1:0]  out_wt_q;
	logic [eusa_pkg::SLOT_W-1:0]    count_q;
	logic                           done_q;

	logic [MW-1:0]                  map_mem [MAX_EXPERTS];
	logic [EW-1:0]                  owner_mem [MAX_SLOTS];
	logic [MW-1:0]                  map_rd_q;
	logic [EW-1:0]                  owner_rd_q;

	logic                           s_accept;
	logic [eusa_pkg::COMMAND_W-1:0] cmd;
	logic                           map_re;
	logic                           map_we;
	logic [EW-1:0]                  map_wa;
	logic [MW-1:0]                  map_wd;
	logic                           walk_rd;
	logic [10:0]                    id_lim;
	logic [eusa_pkg::CAP_W-1:0]     cap_lim;
	logic                           id_bad;
	logic                           col_bad;
	logic                           hit;
	logic                           full;
	logic                           look_new;
	logic                           look_err;
	logic [SW-1:0]                  rt_nxt;
	logic                           out_load;
	logic [eusa_pkg::STATUS_W-1:0]  res_status;
	logic [eusa_pkg::SLOT_W-1:0]    res_slot;
	logic                           res_new;
	logic                           res_ok;
	logic [eusa_pkg::SLOT_W-1:0]    res_count;

	assign cmd      = s_tuser;
	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign s_accept = s_tvalid && s_tready;
	assign map_re   = s_accept && (cmd == eusa_pkg::CMD_ENTRY);
	assign walk_rd  = (state_q == ST_WALK) && (walk_cnt_q < rt_q);

	assign id_lim  = (11'(expert_count_q) < 11'(MAX_EXPERTS)) ?
		11'(expert_count_q) : 11'(MAX_EXPERTS);
	assign cap_lim = (slot_capacity_q < eusa_pkg::CAP_W'(MAX_SLOTS)) ?
		slot_capacity_q : eusa_pkg::CAP_W'(MAX_SLOTS);
	assign id_bad  = {1'b0, id_q} >= id_lim;
	assign col_bad = {1'b0, col_q} >= 4'(MAX_COLUMNS);
	assign hit     = map_rd_q[SW];
	assign full    = (eusa_pkg::CAP_W'(rt_q) + 7'd1) >= cap_lim;
	assign rt_nxt  = rt_q + 1'b1;

	always_comb begin
		look_new = 1'b0;
		look_err = 1'b0;
		res_status = eusa_pkg::STS_OK;
		res_slot = '0;
		res_new = 1'b0;
		res_ok = 1'b0;
		res_count = eusa_pkg::SLOT_W'(rt_q);
		if (state_q == ST_LOOK) begin
			if (err_q) begin
				res_status = eusa_pkg::STS_SKIPPED;
			end else if (id_bad || col_bad) begin
				res_status = eusa_pkg::STS_RANGE;
				look_err = 1'b1;
			end else if (hit) begin
				res_slot = eusa_pkg::SLOT_W'(map_rd_q[SW-1:0]);
				res_ok = 1'b1;
			end else if (full) begin
				res_status = eusa_pkg::STS_OVERFLOW;
				look_err = 1'b1;
			end else begin
				look_new = 1'b1;
				res_slot = eusa_pkg::SLOT_W'(rt_q);
				res_new = 1'b1;
				res_ok = 1'b1;
				res_count = eusa_pkg::SLOT_W'(rt_nxt);
			end
		end else begin
			res_status = err_q ? eusa_pkg::STS_SKIPPED : eusa_pkg::STS_OK;
		end
	end

	assign out_load = (state_q == ST_LOOK) || (s_accept && (cmd == eusa_pkg::CMD_END));

	always_comb begin
		map_we = 1'b0;
		map_wa = id_q[EW-1:0];
		map_wd = {1'b1, rt_q};
		case (state_q)
			ST_CLR: begin
				map_we = 1'b1;
				map_wa = clr_cnt_q;
				map_wd = '0;
			end
			ST_WALK: begin
				map_we = walk_pend_q;
				map_wa = owner_rd_q;
				map_wd = '0;
			end
			ST_LOOK: begin
				map_we = look_new;
			end
			default: begin
				map_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end
		if (map_re) begin
			map_rd_q <= map_mem[s_tdata[eusa_pkg::IN_ID_LSB +: EW]];
		end
	end

	always_ff @(posedge clk) begin
		if (look_new) begin
			owner_mem[rt_q] <= id_q[EW-1:0];
		end
		if (walk_rd) begin
			owner_rd_q <= owner_mem[walk_cnt_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_cnt_q <= '0;
			walk_cnt_q <= '0;
			walk_pend_q <= 1'b0;
			rt_q <= '0;
			err_q <= 1'b0;
			out_valid_q <= 1'b0;
			expert_count_q <= eusa_pkg::EXPERT_COUNT_RST;
			slot_capacity_q <= eusa_pkg::SLOT_CAPACITY_RST;
		end else begin
			if (cfg_wen) begin
				case (cfg_addr)
					eusa_pkg::REG_EXPERT_COUNT: expert_count_q <= cfg_wdata;
					eusa_pkg::REG_SLOT_CAPACITY: begin
						slot_capacity_q <= cfg_wdata[eusa_pkg::CAP_W-1:0];
					end
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == EW'(MAX_EXPERTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_accept) begin
						case (cmd)
							eusa_pkg::CMD_START: begin
								walk_cnt_q <= '0;
								walk_pend_q <= 1'b0;
								state_q <= ST_WALK;
							end
							eusa_pkg::CMD_ENTRY: state_q <= ST_LOOK;
							default: ;
						endcase
					end
				end
				ST_LOOK: begin
					if (look_err) begin
						err_q <= 1'b1;
					end
					if (look_new) begin
						rt_q <= rt_nxt;
					end
					state_q <= ST_IDLE;
				end
				ST_WALK: begin
					walk_pend_q <= walk_rd;
					if (walk_rd) begin
						walk_cnt_q <= walk_cnt_q + 1'b1;
					end else if (!walk_pend_q) begin
						rt_q <= '0;
						err_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			col_q <= s_tdata[eusa_pkg::IN_COL_LSB +: eusa_pkg::COLUMN_W];
			id_q <= s_tdata[eusa_pkg::IN_ID_LSB +: eusa_pkg::ID_W];
			wt_q <= s_tdata[eusa_pkg::IN_WT_LSB +: eusa_pkg::WEIGHT_W];
		end
		if (out_load) begin
			status_q <= res_status;
			slot_q <= res_slot;
			is_new_q <= res_new;
			out_col_q <= res_ok ? col_q : '0;
			out_wt_q <= res_ok ? wt_q : '0;
			count_q <= res_count;
			done_q <= (state_q != ST_LOOK);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tlast  = done_q;

	always_comb begin
		m_tdata = '0;
		m_tdata[eusa_pkg::OUT_SLOT_LSB +: eusa_pkg::SLOT_W] = slot_q;
		m_tdata[eusa_pkg::OUT_NEW_LSB] = is_new_q;
		m_tdata[eusa_pkg::OUT_COL_LSB +: eusa_pkg::COLUMN_W] = out_col_q;
		m_tdata[eusa_pkg::OUT_WT_LSB +: eusa_pkg::WEIGHT_W] = out_wt_q;
		m_tdata[eusa_pkg::OUT_COUNT_LSB +: eusa_pkg::SLOT_W] = count_q;
		m_tdata[eusa_pkg::OUT_SHARED_LSB +: eusa_pkg::SLOT_W] = count_q;
	end

endmodule

// ===== hdl/eusa_checker.sv =====
// Port-level checks of the expert union slot assigner and their binding.
module eusa_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [eusa_pkg::COMMAND_W-1:0]   s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [eusa_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic [eusa_pkg::STATUS_W-1:0]    m_tuser,
	input logic                             m_tlast
);

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_entry_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == eusa_pkg::CMD_ENTRY) |=> !s_tready)
		else $error("item taken while an entry lookup is in flight");

	a_error_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != eusa_pkg::STS_OK) |->
		m_tdata[eusa_pkg::OUT_COUNT_LSB-1:0] == '0)
		else $error("payload not cleared on failed result");

	a_end_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[eusa_pkg::OUT_COUNT_LSB-1:0] == '0)
		else $error("payload not cleared on end result");

	a_shared_is_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[eusa_pkg::OUT_COUNT_LSB +: eusa_pkg::SLOT_W] ==
		m_tdata[eusa_pkg::OUT_SHARED_LSB +: eusa_pkg::SLOT_W])
		else $error("shared slot differs from routed count");

endmodule

bind expert_union_slot_assigner_unit eusa_checker u_eusa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ===== dv/expert_union_slot_assigner_unit_tb.sv =====
// Self-checking testbench for the expert union slot assigner: stream stimulus, slot map predictor.
module expert_union_slot_assigner_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_EXPERTS   = 512;
	localparam int N_SLOTS     = 64;
	localparam int N_COLUMNS   = 8;
	localparam int DRAIN_GAP   = N_SLOTS + 16;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [eusa_pkg::COMMAND_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [eusa_pkg::COMMAND_W-1:0] cmd;
		logic [eusa_pkg::COLUMN_W-1:0]  col;
		logic [eusa_pkg::ID_W-1:0]      id;
		logic [eusa_pkg::WEIGHT_W-1:0]  wt;
	} route_item_t;

	typedef struct packed {
		logic [eusa_pkg::STATUS_W-1:0] status;
		logic [eusa_pkg::SLOT_W-1:0]   slot;
		logic                          is_new;
		logic [eusa_pkg::COLUMN_W-1:0] col;
		logic [eusa_pkg::WEIGHT_W-1:0] wt;
		logic [eusa_pkg::SLOT_W-1:0]   count;
		logic [eusa_pkg::SLOT_W-1:0]   shared;
		logic                          done;
	} grant_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [eusa_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
	logic [eusa_pkg::COMMAND_W-1:0]   s_tuser = '0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [eusa_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic [eusa_pkg::STATUS_W-1:0]    m_tuser;
	logic                             m_tlast;
	logic                             cfg_wen = 1'b0;
	logic [eusa_pkg::CFG_IDX_W-1:0]   cfg_addr = '0;
	logic [eusa_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

	route_item_t route_q[$];
	grant_t      grant_q[$];

	logic                          id_mapped [N_EXPERTS];
	logic [eusa_pkg::SLOT_W-1:0]   id_slot [N_EXPERTS];
	logic [8:0]                    slot_id [N_SLOTS];
	logic [6:0]                    routed;
	logic                          batch_failed;
	logic [eusa_pkg::EC_W-1:0]     expert_count_reg;
	logic [eusa_pkg::CAP_W-1:0]    capacity_reg;

	int send_idle = 0;
	int recv_stall = 0;
	int errors = 0;
	int cycles = 0;
	int hold_left = 0;
	logic hold_go = 1'b0;

	expert_union_slot_assigner_unit #(
		.MAX_EXPERTS(N_EXPERTS),
		.MAX_SLOTS(N_SLOTS),
		.MAX_COLUMNS(N_COLUMNS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_wen(cfg_wen),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic void map_item(input logic [eusa_pkg::COMMAND_W-1:0] cmd,
		input logic [eusa_pkg::COLUMN_W-1:0] col, input logic [eusa_pkg::ID_W-1:0] id,
		input logic [eusa_pkg::WEIGHT_W-1:0] wt);
		grant_t g;
		int unsigned lim;
		int unsigned cap;
		g = '0;
		lim = (expert_count_reg < N_EXPERTS) ? expert_count_reg : N_EXPERTS;
		cap = (capacity_reg < N_SLOTS) ? capacity_reg : N_SLOTS;
		case (cmd)
			eusa_pkg::CMD_START: begin
				for (int u = 0; u < routed; u++)
					id_mapped[slot_id[u]] = 1'b0;
				routed = '0;
				batch_failed = 1'b0;
			end
			eusa_pkg::CMD_END: begin
				g.status = batch_failed ? eusa_pkg::STS_SKIPPED : eusa_pkg::STS_OK;
				g.done = 1'b1;
				g.count = routed[eusa_pkg::SLOT_W-1:0];
				g.shared = routed[eusa_pkg::SLOT_W-1:0];
				grant_q.insert(grant_q.size(), g);
			end
			eusa_pkg::CMD_ENTRY: begin
				if (batch_failed) begin
					g.status = eusa_pkg::STS_SKIPPED;
				end else if (id >= lim || col >= N_COLUMNS) begin
					batch_failed = 1'b1;
					g.status = eusa_pkg::STS_RANGE;
				end else if (id_mapped[id[8:0]]) begin
					g.status = eusa_pkg::STS_OK;
					g.slot = id_slot[id[8:0]];
					g.col = col;
					g.wt = wt;
				end else if (routed + 1 >= cap) begin
					batch_failed = 1'b1;
					g.status = eusa_pkg::STS_OVERFLOW;
				end else begin
					id_mapped[id[8:0]] = 1'b1;
					id_slot[id[8:0]] = routed[eusa_pkg::SLOT_W-1:0];
					slot_id[routed[eusa_pkg::SLOT_W-1:0]] = id[8:0];
					g.status = eusa_pkg::STS_OK;
					g.slot = routed[eusa_pkg::SLOT_W-1:0];
					g.is_new = 1'b1;
					g.col = col;
					g.wt = wt;
					routed = routed + 7'd1;
				end
				g.count = routed[eusa_pkg::SLOT_W-1:0];
				g.shared = routed[eusa_pkg::SLOT_W-1:0];
				grant_q.insert(grant_q.size(), g);
			end
			default: ;
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t %s expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	function automatic void push_item(input logic [eusa_pkg::COMMAND_W-1:0] cmd,
		input logic [eusa_pkg::COLUMN_W-1:0] col, input logic [eusa_pkg::ID_W-1:0] id,
		input logic [eusa_pkg::WEIGHT_W-1:0] wt);
		route_item_t it;
		it.cmd = cmd;
		it.col = col;
		it.id = id;
		it.wt = wt;
		route_q.insert(route_q.size(), it);
	endfunction

	always @(posedge clk) begin : driver
		route_item_t it;
		logic [eusa_pkg::IN_TDATA_W-1:0] d;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (route_q.size() != 0 && $urandom_range(99) >= send_idle) begin
				it = route_q.pop_front();
				d = '0;
				d[eusa_pkg::IN_COL_LSB +: eusa_pkg::COLUMN_W] = it.col;
				d[eusa_pkg::IN_ID_LSB +: eusa_pkg::ID_W] = it.id;
				d[eusa_pkg::IN_WT_LSB +: eusa_pkg::WEIGHT_W] = it.wt;
				s_tdata <= d;
				s_tuser <= it.cmd;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (hold_go)
			hold_left <= HOLD_CYCLES;
		else if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk) begin
		m_tready <= (hold_left == 0 && !hold_go) && ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			map_item(s_tuser, s_tdata[eusa_pkg::IN_COL_LSB +: eusa_pkg::COLUMN_W],
				s_tdata[eusa_pkg::IN_ID_LSB +: eusa_pkg::ID_W],
				s_tdata[eusa_pkg::IN_WT_LSB +: eusa_pkg::WEIGHT_W]);
	end

	always @(posedge clk) begin : monitor
		grant_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (grant_q.size() == 0) begin
				$display("%0t result with nothing expected: expected none actual status %0h data %0h",
					$time, m_tuser, m_tdata);
				errors++;
			end else begin
				want = grant_q.pop_front();
				check_field("status", 32'(want.status), 32'(m_tuser));
				check_field("slot", 32'(want.slot),
					32'(m_tdata[eusa_pkg::OUT_SLOT_LSB +: eusa_pkg::SLOT_W]));
				check_field("is_new", 32'(want.is_new), 32'(m_tdata[eusa_pkg::OUT_NEW_LSB]));
				check_field("out_column", 32'(want.col),
					32'(m_tdata[eusa_pkg::OUT_COL_LSB +: eusa_pkg::COLUMN_W]));
				check_field("out_weight_bits", want.wt,
					m_tdata[eusa_pkg::OUT_WT_LSB +: eusa_pkg::WEIGHT_W]);
				check_field("routed_count", 32'(want.count),
					32'(m_tdata[eusa_pkg::OUT_COUNT_LSB +: eusa_pkg::SLOT_W]));
				check_field("shared_slot", 32'(want.shared),
					32'(m_tdata[eusa_pkg::OUT_SHARED_LSB +: eusa_pkg::SLOT_W]));
				check_field("batch_done", 32'(want.done), 32'(m_tlast));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("expert_union_slot_assigner_unit: mismatch");
			$finish;
		end
	end

	task automatic write_reg(input logic [eusa_pkg::CFG_IDX_W-1:0] idx,
		input logic [eusa_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		if (idx == eusa_pkg::REG_EXPERT_COUNT)
			expert_count_reg = val[eusa_pkg::EC_W-1:0];
		else
			capacity_reg = val[eusa_pkg::CAP_W-1:0];
	endtask

	task automatic set_config(input int ec, input int cap);
		write_reg(eusa_pkg::REG_EXPERT_COUNT, eusa_pkg::CFG_DATA_W'(ec));
		write_reg(eusa_pkg::REG_SLOT_CAPACITY, eusa_pkg::CFG_DATA_W'(cap));
	endtask

	// hold until every item is in, every result is out and the last start has finished its walk
	task automatic drain();
		while (route_q.size() != 0 || s_tvalid || grant_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic queue_batches(input int target);
		int made;
		int n;
		int lim;
		int capn;
		int pool_n;
		int base;
		bit wide;
		logic [eusa_pkg::ID_W-1:0] id;
		logic [eusa_pkg::ID_W-1:0] pool [16];
		made = 0;
		lim = (expert_count_reg < N_EXPERTS) ? expert_count_reg : N_EXPERTS;
		capn = (capacity_reg < N_SLOTS) ? capacity_reg : N_SLOTS;
		while (made < target) begin
			if ($urandom_range(99) < 4)
				push_item(CMD_UNUSED, eusa_pkg::COLUMN_W'($urandom_range(7)),
					eusa_pkg::ID_W'($urandom_range(1023)), $urandom);
			if ($urandom_range(99) >= 8) begin
				push_item(eusa_pkg::CMD_START, eusa_pkg::COLUMN_W'($urandom_range(7)),
					eusa_pkg::ID_W'($urandom_range(1023)), $urandom);
				made++;
			end
			wide = ($urandom_range(19) == 0);
			n = wide ? capn + 4 : $urandom_range(1, 12);
			pool_n = $urandom_range(1, 16);
			for (int k = 0; k < pool_n; k++)
				pool[k] = (lim > 0) ? eusa_pkg::ID_W'($urandom_range(lim - 1)) :
					eusa_pkg::ID_W'($urandom_range(1023));
			base = (lim > 0) ? $urandom_range(lim - 1) : 0;
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(99) < 5)
					id = eusa_pkg::ID_W'($urandom_range(1023));
				else if (wide && lim > 0)
					id = eusa_pkg::ID_W'((base + i) % lim);
				else
					id = pool[$urandom_range(pool_n - 1)];
				push_item(eusa_pkg::CMD_ENTRY, eusa_pkg::COLUMN_W'($urandom_range(7)), id,
					$urandom);
				made++;
			end
			if ($urandom_range(99) >= 5) begin
				push_item(eusa_pkg::CMD_END, eusa_pkg::COLUMN_W'($urandom_range(7)),
					eusa_pkg::ID_W'($urandom_range(1023)), $urandom);
				made++;
			end
		end
	endtask

	initial begin
		int ec_set [6];
		int cap_set [6];
		int send_set [6];
		int recv_set [6];
		ec_set   = '{512, 40, 1023, 1, 300, 512};
		cap_set  = '{64, 8, 127, 2, 17, 64};
		send_set = '{0, 47, 0, 22, 0, 47};
		recv_set = '{0, 0, 47, 22, 0, 47};
		for (int i = 0; i < N_EXPERTS; i++) begin
			id_mapped[i] = 1'b0;
			id_slot[i] = '0;
		end
		for (int i = 0; i < N_SLOTS; i++)
			slot_id[i] = '0;
		routed = '0;
		batch_failed = 1'b0;
		expert_count_reg = eusa_pkg::EXPERT_COUNT_RST;
		capacity_reg = eusa_pkg::SLOT_CAPACITY_RST;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// entries before any start, repeat hit, clear after a failed batch
		push_item(eusa_pkg::CMD_ENTRY, 3'd0, 10'd0, 32'h0000_0000);
		push_item(eusa_pkg::CMD_ENTRY, 3'd7, 10'd511, 32'hFFFF_FFFF);
		push_item(eusa_pkg::CMD_ENTRY, 3'd3, 10'd0, 32'h3F80_0000);
		push_item(eusa_pkg::CMD_END, 3'd7, 10'd1023, 32'hFFFF_FFFF);
		push_item(eusa_pkg::CMD_START, 3'd0, 10'd0, 32'h0);
		push_item(eusa_pkg::CMD_ENTRY, 3'd1, 10'd511, 32'h8000_0001);
		push_item(eusa_pkg::CMD_ENTRY, 3'd2, 10'd512, 32'h1234_5678);
		push_item(eusa_pkg::CMD_ENTRY, 3'd4, 10'd5, 32'hDEAD_BEEF);
		push_item(eusa_pkg::CMD_END, 3'd0, 10'd0, 32'h0);
		push_item(CMD_UNUSED, 3'd7, 10'd1023, 32'hFFFF_FFFF);
		push_item(eusa_pkg::CMD_START, 3'd0, 10'd0, 32'h0);
		push_item(eusa_pkg::CMD_ENTRY, 3'd5, 10'd1023, 32'h7FFF_FFFF);
		push_item(eusa_pkg::CMD_END, 3'd0, 10'd0, 32'h0);
		push_item(eusa_pkg::CMD_START, 3'd0, 10'd0, 32'h0);
		push_item(eusa_pkg::CMD_END, 3'd0, 10'd0, 32'h0);
		drain();

		// smallest capacity: one routed slot, then overflow
		set_config(3, 2);
		push_item(eusa_pkg::CMD_START, 3'd0, 10'd0, 32'h0);
		push_item(eusa_pkg::CMD_ENTRY, 3'd6, 10'd2, 32'hC000_0000);
		push_item(eusa_pkg::CMD_ENTRY, 3'd6, 10'd2, 32'h4000_0000);
		push_item(eusa_pkg::CMD_ENTRY, 3'd1, 10'd1, 32'h1);
		push_item(eusa_pkg::CMD_ENTRY, 3'd0, 10'd0, 32'h2);
		push_item(eusa_pkg::CMD_END, 3'd0, 10'd0, 32'h0);
		push_item(eusa_pkg::CMD_START, 3'd0, 10'd0, 32'h0);
		push_item(eusa_pkg::CMD_ENTRY, 3'd2, 10'd3, 32'h5);
		push_item(eusa_pkg::CMD_END, 3'd0, 10'd0, 32'h0);
		drain();

		// zero expert count and zero capacity
		set_config(0, 0);
		push_item(eusa_pkg::CMD_START, 3'd0, 10'd0, 32'h0);
		push_item(eusa_pkg::CMD_ENTRY, 3'd0, 10'd0, 32'h9);
		push_item(eusa_pkg::CMD_END, 3'd0, 10'd0, 32'h0);
		drain();
		set_config(1023, 0);
		push_item(eusa_pkg::CMD_START, 3'd0, 10'd0, 32'h0);
		push_item(eusa_pkg::CMD_ENTRY, 3'd3, 10'd511, 32'hA);
		push_item(eusa_pkg::CMD_ENTRY, 3'd3, 10'd512, 32'hB);
		push_item(eusa_pkg::CMD_END, 3'd0, 10'd0, 32'h0);
		drain();

		for (int p = 0; p < 6; p++) begin
			set_config(ec_set[p], cap_set[p]);
			send_idle = send_set[p];
			recv_stall = recv_set[p];
			queue_batches(110);
			if (p == 4) begin
				@(posedge clk);
				hold_go <= 1'b1;
				@(posedge clk);
				hold_go <= 1'b0;
			end
			drain();
		end

		if (errors == 0)
			$display("expert_union_slot_assigner_unit: match");
		else
			$display("expert_union_slot_assigner_unit: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/eusa_pkg.sv
hdl/expert_union_slot_assigner_unit.sv
hdl/eusa_checker.sv
dv/expert_union_slot_assigner_unit_tb.sv
